// ===== design/ibxc_pkg.sv =====
// Shared types and constants for the interleaved block XOR cipher.
// Used by ibxc_ctrl, ibxc_dp and interleaved_block_xor_cipher; no dependencies.
`default_nettype none

package ibxc_pkg;

    localparam int MAX_BLOCK  = 1024;
    localparam int BLK_W      = $clog2(MAX_BLOCK + 1);
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 8;
    localparam int DIV_STEPS  = WORD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_KEY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 3'd5;

    localparam logic MODE_DECRYPT = 1'b0;
    localparam logic MODE_ENCRYPT = 1'b1;

    localparam logic [BLK_W-1:0] BLOCK_SIZE_RESET = BLK_W'(128);

    typedef struct packed {
        logic              cipher_mode;
        logic [KEY_W-1:0]  start_key;
        logic [KEY_W-1:0]  key_step;
        logic [BLK_W-1:0]  block_size;
        logic [WORD_W-1:0] byte_limit;
        logic [WORD_W-1:0] message_length;
    } ibxc_cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic trim;
        logic finish;
        logic check;
        logic blk;
        logic dest;
        logic emit;
    } ibxc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } ibxc_sts_t;

endpackage

`default_nettype wire

// ===== design/ibxc_dp.sv =====
// Datapath: remainder unit, message trim, block/permutation math and output register.
// Driven by ibxc_ctrl through ibxc_cmd_t; depends on ibxc_pkg.
`default_nettype none

module ibxc_dp
    import ibxc_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire ibxc_cfg_t     cfg,
    input  wire ibxc_cmd_t     cmd,
    output ibxc_sts_t          sts,
    input  wire [KEY_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [39:0]        m_tdata,
    output logic               m_tuser
);

    logic [BLK_W-1:0]     eff_b;
    logic [BLK_W-1:0]     quarter;

    logic [KEY_W-1:0]     byte_reg;
    logic [WORD_W-1:0]    szx_reg, szx_next;
    logic [WORD_W-1:0]    limx_reg, limx_next;
    logic [BLK_W-1:0]     rsz_reg, rsz_next;
    logic [BLK_W-1:0]     rlim_reg, rlim_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BLK_W:0]       rsz_sh, rlim_sh;

    logic [WORD_W-1:0]    sz_trim_reg, sz_trim_next;
    logic [WORD_W:0]      lim_up_reg, lim_up_next;
    logic [WORD_W-1:0]    sz_sub;
    logic [WORD_W-1:0]    pend_next;

    logic [WORD_W-1:0]    pos_reg, base_reg, pend_reg;
    logic [BLK_W-1:0]     idx_reg, len_reg, half_reg;
    logic [KEY_W-1:0]     bsk_reg;
    logic                 inreg_reg;
    logic [WORD_W-1:0]    left_reg;
    logic [BLK_W-1:0]     len_next, half_next;
    logic [BLK_W-1:0]     dest_reg, dest_next;
    logic [BLK_W-1:0]     t_val;
    logic [BLK_W-1:0]     idx_inc;

    logic [KEY_W-1:0]     mul_sel;
    logic [2*KEY_W-1:0]   key_prod, adv_prod;
    logic [KEY_W-1:0]     key_val;

    logic                 m_valid_reg;
    logic [KEY_W-1:0]     m_byte_reg;
    logic [WORD_W-1:0]    m_off_reg;
    logic                 m_xf_reg;

    always_comb begin
        if (cfg.block_size == '0) begin
            eff_b = BLK_W'(1);
        end else if (cfg.block_size > BLK_W'(MAX_BLOCK)) begin
            eff_b = BLK_W'(MAX_BLOCK);
        end else begin
            eff_b = cfg.block_size;
        end
        quarter = eff_b >> 2;
    end

    // restoring remainder, one bit per cycle on both dividends
    always_comb begin
        rsz_sh  = {rsz_reg, szx_reg[WORD_W-1]};
        rlim_sh = {rlim_reg, limx_reg[WORD_W-1]};
        szx_next  = {szx_reg[WORD_W-2:0], 1'b0};
        limx_next = {limx_reg[WORD_W-2:0], 1'b0};
        if (rsz_sh >= {1'b0, eff_b}) begin
            rsz_next = BLK_W'(rsz_sh - {1'b0, eff_b});
        end else begin
            rsz_next = rsz_sh[BLK_W-1:0];
        end
        if (rlim_sh >= {1'b0, eff_b}) begin
            rlim_next = BLK_W'(rlim_sh - {1'b0, eff_b});
        end else begin
            rlim_next = rlim_sh[BLK_W-1:0];
        end
    end

    always_comb begin
        sz_sub = ((rsz_reg < quarter) ? WORD_W'(rsz_reg) : '0)
               + WORD_W'(cfg.message_length[0]);
        if (cfg.message_length < WORD_W'(quarter)) begin
            sz_trim_next = '0;
        end else begin
            sz_trim_next = cfg.message_length - sz_sub;
        end
        if (rlim_reg != '0) begin
            lim_up_next = {1'b0, cfg.byte_limit} + (WORD_W+1)'(eff_b - rlim_reg);
        end else begin
            lim_up_next = {1'b0, cfg.byte_limit};
        end
        pend_next = ({1'b0, sz_trim_reg} < lim_up_reg) ? sz_trim_reg
                                                        : lim_up_reg[WORD_W-1:0];
    end

    always_comb begin
        if (left_reg < WORD_W'(eff_b)) begin
            len_next = left_reg[BLK_W-1:0];
        end else begin
            len_next = eff_b;
        end
        half_next = BLK_W'(({1'b0, len_next} + 1'b1) >> 1);
    end

    always_comb begin
        t_val = len_reg - BLK_W'(1) - idx_reg;
        if (cfg.cipher_mode == MODE_DECRYPT) begin
            if (idx_reg < half_reg) begin
                dest_next = len_reg - BLK_W'(1) - {idx_reg[BLK_W-2:0], 1'b0};
            end else begin
                dest_next = len_reg - BLK_W'(2) - BLK_W'({idx_reg - half_reg, 1'b0});
            end
        end else begin
            if (!t_val[0]) begin
                dest_next = t_val >> 1;
            end else begin
                dest_next = (t_val >> 1) + half_reg;
            end
        end
    end

    always_comb begin
        mul_sel  = (cfg.cipher_mode == MODE_DECRYPT) ? idx_reg[KEY_W-1:0]
                                                     : dest_reg[KEY_W-1:0];
        key_prod = mul_sel * cfg.key_step;
        key_val  = bsk_reg + key_prod[KEY_W-1:0];
        adv_prod = {half_reg[KEY_W-2:0], 1'b0} * cfg.key_step;
        idx_inc  = idx_reg + BLK_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pos_reg     <= '0;
            base_reg    <= '0;
            pend_reg    <= '0;
            idx_reg     <= '0;
            len_reg     <= '0;
            half_reg    <= '0;
            bsk_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.finish) begin
                pend_reg <= pend_next;
                pos_reg  <= '0;
                base_reg <= '0;
                idx_reg  <= '0;
                len_reg  <= '0;
                half_reg <= '0;
                bsk_reg  <= cfg.start_key;
            end
            if (cmd.blk && inreg_reg && idx_reg == '0) begin
                len_reg  <= len_next;
                half_reg <= half_next;
            end
            if (cmd.emit) begin
                pos_reg <= pos_reg + WORD_W'(1);
                if (inreg_reg) begin
                    if (idx_inc >= len_reg) begin
                        idx_reg  <= '0;
                        base_reg <= base_reg + WORD_W'(len_reg);
                        bsk_reg  <= bsk_reg + adv_prod[KEY_W-1:0];
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
            szx_reg  <= cfg.message_length;
            limx_reg <= cfg.byte_limit;
            rsz_reg  <= '0;
            rlim_reg <= '0;
        end else if (cmd.div_step) begin
            szx_reg  <= szx_next;
            limx_reg <= limx_next;
            rsz_reg  <= rsz_next;
            rlim_reg <= rlim_next;
        end
        if (cmd.trim) begin
            sz_trim_reg <= sz_trim_next;
            lim_up_reg  <= lim_up_next;
        end
        if (cmd.check) begin
            inreg_reg <= pos_reg < pend_reg;
            left_reg  <= pend_reg - pos_reg;
        end
        if (cmd.dest) begin
            dest_reg <= dest_next;
        end
        if (cmd.emit) begin
            if (inreg_reg) begin
                m_byte_reg <= byte_reg ^ key_val;
                m_off_reg  <= base_reg + WORD_W'(dest_reg);
                m_xf_reg   <= 1'b1;
            end else begin
                m_byte_reg <= byte_reg;
                m_off_reg  <= pos_reg;
                m_xf_reg   <= 1'b0;
            end
        end
    end

    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_off_reg, m_byte_reg};
    assign m_tuser  = m_xf_reg;

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emit did not load the output register");

    a_emit_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_index_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> idx_reg < len_reg)
        else $error("block index ran past block length");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !cmd.finish |=> pos_reg == $past(pos_reg) + WORD_W'(1))
        else $error("message position did not advance");

endmodule

`default_nettype wire

// ===== design/ibxc_ctrl.sv =====
// Controller: per byte accept, remainder+trim (first byte), block math, emit.
// Drives ibxc_dp through ibxc_cmd_t; depends on ibxc_pkg.
`default_nettype none

module ibxc_ctrl
    import ibxc_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_tvalid,
    input  wire            s_tuser,
    output logic           s_tready,
    input  wire ibxc_sts_t sts,
    output ibxc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_TRIM, S_END, S_CHECK, S_BLK, S_DEST, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.div_step = (state_reg == S_DIV);
        cmd.trim     = (state_reg == S_TRIM);
        cmd.finish   = (state_reg == S_END);
        cmd.check    = (state_reg == S_CHECK);
        cmd.blk      = (state_reg == S_BLK);
        cmd.dest     = (state_reg == S_DEST);
        cmd.emit     = (state_reg == S_EMIT) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = s_tuser ? S_DIV : S_CHECK;
                end
            end
            S_DIV: begin
                if (sts.div_last) begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM:  state_next = S_END;
            S_END:   state_next = S_CHECK;
            S_CHECK: state_next = S_BLK;
            S_BLK:   state_next = S_DEST;
            S_DEST:  state_next = S_EMIT;
            S_EMIT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction left controller idle");

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && !sts.out_free |=> state_reg == S_EMIT)
        else $error("result dropped while output held");

    a_first_runs_div: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser |=> state_reg == S_DIV)
        else $error("first byte skipped message setup");

endmodule

`default_nettype wire

// ===== design/interleaved_block_xor_cipher.sv =====
// Top level of the interleaved block XOR cipher: config registers, controller, datapath.
// Depends on ibxc_pkg, ibxc_ctrl and ibxc_dp.
//
//  channel  handshake               payload
//  s_       s_tvalid / s_tready     s_tdata[7:0] data_byte, s_tuser first_of_message
//  m_       m_tvalid / m_tready     m_tdata[7:0] out_byte, [39:8] out_offset,
//                                   m_tuser was_transformed
//  cfg_     cfg_valid / cfg_ready   cfg_index register index, cfg_data value
//
// A byte goes through these steps from acceptance to result: accept, compare, block length,
// destination, key and output load.
// A byte with first_of_message adds the bit-serial remainder unit (message length
// and byte limit modulo block size together) and the trim steps.
// The output register lets a result wait while the next byte is accepted; the
// next result waits in the last step until the output register is taken.
// Reset is synchronous, active low; cfg_ready is always high.
`default_nettype none

module interleaved_block_xor_cipher
    import ibxc_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [7:0]            s_tdata,   // [7:0] data_byte
    input  wire                  s_tuser,   // [0] first_of_message
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [39:0]          m_tdata,   // [7:0] out_byte, [39:8] out_offset
    output logic                 m_tuser,   // [0] was_transformed
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [WORD_W-1:0]     cfg_data
);

    ibxc_cfg_t cfg_reg;
    ibxc_cmd_t cmd;
    ibxc_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cipher_mode    <= MODE_DECRYPT;
            cfg_reg.start_key      <= '0;
            cfg_reg.key_step       <= '0;
            cfg_reg.block_size     <= BLOCK_SIZE_RESET;
            cfg_reg.byte_limit     <= '0;
            cfg_reg.message_length <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CIPHER_MODE:    cfg_reg.cipher_mode    <= cfg_data[0];
                REG_START_KEY:      cfg_reg.start_key      <= cfg_data[KEY_W-1:0];
                REG_KEY_STEP:       cfg_reg.key_step       <= cfg_data[KEY_W-1:0];
                REG_BLOCK_SIZE:     cfg_reg.block_size     <= cfg_data[BLK_W-1:0];
                REG_BYTE_LIMIT:     cfg_reg.byte_limit     <= cfg_data;
                REG_MESSAGE_LENGTH: cfg_reg.message_length <= cfg_data;
                default: ;
            endcase
        end
    end

    ibxc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ibxc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
